// File: hdl/lcr_pkg.sv
// Shared widths, codes, reset values and control structs for the load cell reader.
package lcr_pkg;

   localparam int SAMPLE_BITS_DEF   = 24;
   localparam int MAX_SAMPLES_DEF   = 64;
   localparam int FRACTION_BITS_DEF = 8;

   localparam int CMD_W      = 2;
   localparam int COUNT_W    = 7;
   localparam int SCALE_W    = 24;
   localparam int LIMIT_W    = 16;
   localparam int HALF_W     = 8;
   localparam int OFFSET_W   = 24;
   localparam int UNITS_W    = 24;
   localparam int RAW_W      = 24;
   localparam int PROD_W     = LIMIT_W + SCALE_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [COUNT_W-1:0] COUNT_RST = 7'd10;
   localparam logic [SCALE_W-1:0] SCALE_RST = 24'd17000;
   localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'd300;
   localparam logic [HALF_W-1:0]  HALF_RST  = 8'd1;

   localparam logic [UNITS_W-1:0] UNITS_MAX = {UNITS_W{1'b1}};

   localparam logic [CMD_W-1:0] CMD_NONE    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MEASURE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TARE    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_DIV    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNITS_LIMIT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_PERIOD  = 2'd3;

   typedef struct packed {
      logic               clock_pin;
      logic               busy_res;
      logic               done_res;
      logic               was_tare;
      logic               out_of_range;
      logic [UNITS_W-1:0] units_q8;
      logic [RAW_W-1:0]   raw_average;
   } lcr_res_type;

   typedef struct packed {
      logic tick_en;
      logic div_avg_start;
      logic avg_load;
      logic mul_load;
      logic oor_set;
      logic div_units_start;
      logic units_load;
      logic rsp_load;
   } lcr_cmd_type;

   typedef struct packed {
      logic finish;
      logic tare;
      logic div_done;
      logic oor;
   } lcr_sts_type;

endpackage

// File: hdl/lcr_divider.sv
// Restoring divider, one quotient bit per cycle.
module lcr_divider
   import lcr_pkg::*;
#(
   parameter int DVD_W = 32,
   parameter int DVS_W = SCALE_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   trial_sub;
   logic             fits;

   always_comb begin
      trial     = {rem_ff, quo_ff[DVD_W-1]};
      trial_sub = trial - {1'b0, dvs_ff};
      fits      = trial >= {1'b0, dvs_ff};
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hdl/lcr_datapath.sv
// Converter serial sequencing, averaging, tare and weight datapath.
module lcr_datapath
   import lcr_pkg::*;
#(
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int MAX_SAMPLES   = MAX_SAMPLES_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [CMD_W-1:0]      req_command,
   input  logic                  req_data_pin,
   input  lcr_cmd_type           cmd_i,
   output lcr_sts_type           sts_o,
   output lcr_res_type           rsp_o
);

   localparam int BIT_W  = $clog2(SAMPLE_BITS + 1);
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_SAMPLES);
   localparam int WGT_W  = SAMPLE_BITS + FRACTION_BITS;
   localparam int DVD_W  = (SUM_W > WGT_W) ? SUM_W : WGT_W;
   localparam int QX_W   = (DVD_W > UNITS_W) ? DVD_W : UNITS_W;
   localparam int AX_W   = (SAMPLE_BITS > RAW_W) ? SAMPLE_BITS : RAW_W;
   localparam int DIFF_W = ((SAMPLE_BITS > OFFSET_W) ? SAMPLE_BITS : OFFSET_W) + 1;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_WAIT = 4'b0010,
      PH_HIGH = 4'b0100,
      PH_LOW  = 4'b1000
   } lcr_phase_type;

   // configuration
   logic [COUNT_W-1:0] cfg_count_ff;
   logic [SCALE_W-1:0] cfg_scale_ff;
   logic [LIMIT_W-1:0] cfg_limit_ff;
   logic [HALF_W-1:0]  cfg_half_ff;

   // converter read state
   lcr_phase_type          phase_ff, phase_in;
   logic [HALF_W-1:0]      tick_ff, tick_in;
   logic [BIT_W-1:0]       bit_ff, bit_in;
   logic [SAMPLE_BITS-1:0] shift_ff, shift_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [CNT_W-1:0]       sdone_ff, sdone_in;
   logic [OFFSET_W-1:0]    offset_ff;
   logic                   tare_ff, tare_in;
   logic                   clock_ff, clock_in;
   logic                   finish;

   // result path
   logic [SAMPLE_BITS-1:0] avg_ff;
   logic [SAMPLE_BITS-1:0] diff_ff;
   logic                   neg_ff;
   logic [PROD_W-1:0]      prod_ff;
   lcr_res_type            stg_ff;
   lcr_res_type            rsp_ff;

   logic [HALF_W-1:0]      half_eff;
   logic [SCALE_W-1:0]     scale_eff;
   logic [8:0]             count_wide;
   logic [CNT_W-1:0]       count_eff;
   logic [HALF_W:0]        tick_inc;
   logic                   tick_wrap;
   logic [SAMPLE_BITS-1:0] sample_val;
   logic [CNT_W-1:0]       sdone_inc;

   logic                   div_start;
   logic [DVD_W-1:0]       div_dividend;
   logic [SCALE_W-1:0]     div_divisor;
   logic                   div_done;
   logic [DVD_W-1:0]       div_quot;

   logic [AX_W-1:0]        avg_x;
   logic [RAW_W-1:0]       avg_low;
   logic [QX_W-1:0]        quot_x;
   logic [UNITS_W-1:0]     units_sat;
   logic [DIFF_W-1:0]      diff_w;

   always_comb begin
      half_eff   = (cfg_half_ff == '0) ? HALF_W'(1) : cfg_half_ff;
      scale_eff  = (cfg_scale_ff == '0) ? SCALE_W'(1) : cfg_scale_ff;
      count_wide = {2'b00, cfg_count_ff};
      if (cfg_count_ff == '0) begin
         count_eff = CNT_W'(1);
      end else if (count_wide > 9'(MAX_SAMPLES)) begin
         count_eff = CNT_W'(MAX_SAMPLES);
      end else begin
         count_eff = CNT_W'(count_wide);
      end
   end

   // one timebase tick of the converter read
   always_comb begin
      tick_inc   = {1'b0, tick_ff} + (HALF_W + 1)'(1);
      tick_wrap  = tick_inc >= {1'b0, half_eff};
      sample_val = shift_ff ^ {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
      sdone_inc  = sdone_ff + CNT_W'(1);
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      sum_in     = sum_ff;
      sdone_in   = sdone_ff;
      tare_in    = tare_ff;
      clock_in   = clock_ff;
      finish     = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            clock_in = 1'b0;
            if (req_command == CMD_MEASURE || req_command == CMD_TARE) begin
               tare_in  = (req_command == CMD_TARE);
               sum_in   = '0;
               sdone_in = '0;
               tick_in  = '0;
               phase_in = PH_WAIT;
            end
         end
         PH_WAIT: begin
            if (tick_ff == '0 && !req_data_pin) begin
               shift_in = '0;
               bit_in   = '0;
               clock_in = 1'b1;
               phase_in = PH_HIGH;
            end else begin
               tick_in = tick_wrap ? '0 : tick_inc[HALF_W-1:0];
            end
         end
         PH_HIGH: begin
            if (tick_wrap) begin
               tick_in  = '0;
               clock_in = 1'b0;
               // the extra pulse after the last data bit closes the conversion
               if (bit_ff >= BIT_W'(SAMPLE_BITS)) begin
                  sum_in   = sum_ff + SUM_W'(sample_val);
                  sdone_in = sdone_inc;
                  if (sdone_inc >= count_eff) begin
                     finish   = 1'b1;
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in = PH_WAIT;
                  end
               end else begin
                  phase_in = PH_LOW;
               end
            end else begin
               tick_in = tick_inc[HALF_W-1:0];
            end
         end
         PH_LOW: begin
            if (tick_wrap) begin
               tick_in  = '0;
               shift_in = {shift_ff[SAMPLE_BITS-2:0], req_data_pin};
               bit_in   = bit_ff + BIT_W'(1);
               clock_in = 1'b1;
               phase_in = PH_HIGH;
            end else begin
               tick_in = tick_inc[HALF_W-1:0];
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_count_ff <= COUNT_RST;
         cfg_scale_ff <= SCALE_RST;
         cfg_limit_ff <= LIMIT_RST;
         cfg_half_ff  <= HALF_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SAMPLE_COUNT: cfg_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_SCALE_DIV:    cfg_scale_ff <= csr_wdata[SCALE_W-1:0];
            CSR_UNITS_LIMIT:  cfg_limit_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_HALF_PERIOD:  cfg_half_ff  <= csr_wdata[HALF_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         tick_ff   <= '0;
         bit_ff    <= '0;
         shift_ff  <= '0;
         sum_ff    <= '0;
         sdone_ff  <= '0;
         tare_ff   <= 1'b0;
         clock_ff  <= 1'b0;
         offset_ff <= '0;
      end else begin
         if (cmd_i.tick_en) begin
            phase_ff <= phase_in;
            tick_ff  <= tick_in;
            bit_ff   <= bit_in;
            shift_ff <= shift_in;
            sum_ff   <= sum_in;
            sdone_ff <= sdone_in;
            tare_ff  <= tare_in;
            clock_ff <= clock_in;
         end
         if (cmd_i.avg_load && tare_ff) begin
            offset_ff <= avg_low;
         end
      end
   end

   // the average divides the sum being written this cycle
   always_comb begin
      div_start = cmd_i.div_avg_start || cmd_i.div_units_start;
      if (cmd_i.div_avg_start) begin
         div_dividend = DVD_W'(sum_in);
         div_divisor  = SCALE_W'(count_eff);
      end else begin
         div_dividend = DVD_W'(diff_ff) << FRACTION_BITS;
         div_divisor  = scale_eff;
      end
   end

   lcr_divider #(
      .DVD_W (DVD_W),
      .DVS_W (SCALE_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      avg_x     = AX_W'(div_quot[SAMPLE_BITS-1:0]);
      avg_low   = avg_x[RAW_W-1:0];
      quot_x    = QX_W'(div_quot);
      units_sat = (quot_x > QX_W'(UNITS_MAX)) ? UNITS_MAX : quot_x[UNITS_W-1:0];
      diff_w    = DIFF_W'(avg_ff) - DIFF_W'(offset_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd_i.avg_load) begin
         avg_ff <= div_quot[SAMPLE_BITS-1:0];
      end
      if (cmd_i.mul_load) begin
         prod_ff <= PROD_W'(cfg_limit_ff) * PROD_W'(scale_eff);
         neg_ff  <= diff_w[DIFF_W-1];
         diff_ff <= diff_w[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      priority if (cmd_i.tick_en) begin
         stg_ff.clock_pin    <= clock_in;
         stg_ff.busy_res     <= (phase_in != PH_IDLE);
         stg_ff.done_res     <= 1'b0;
         stg_ff.was_tare     <= 1'b0;
         stg_ff.out_of_range <= 1'b0;
         stg_ff.units_q8     <= '0;
         stg_ff.raw_average  <= '0;
      end else if (cmd_i.avg_load) begin
         stg_ff.clock_pin    <= 1'b0;
         stg_ff.busy_res     <= 1'b0;
         stg_ff.done_res     <= 1'b1;
         stg_ff.was_tare     <= tare_ff;
         stg_ff.out_of_range <= 1'b0;
         stg_ff.units_q8     <= '0;
         stg_ff.raw_average  <= avg_low;
      end else if (cmd_i.oor_set) begin
         stg_ff.out_of_range <= 1'b1;
      end else if (cmd_i.units_load) begin
         stg_ff.units_q8 <= units_sat;
      end else begin
         stg_ff <= stg_ff;
      end
      if (cmd_i.rsp_load) begin
         rsp_ff <= stg_ff;
      end
   end

   always_comb begin
      sts_o.finish   = finish;
      sts_o.tare     = tare_ff;
      sts_o.div_done = div_done;
      sts_o.oor      = neg_ff || (PROD_W'(diff_ff) >= prod_ff);
   end

   assign rsp_o = rsp_ff;

endmodule

// File: hdl/lcr_controller.sv
// Request sequencer: tick acceptance, result computation steps, output handoff.
module lcr_controller
   import lcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  lcr_sts_type sts_i,
   output lcr_cmd_type cmd_o
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_AVG   = 6'b000010,
      ST_MUL   = 6'b000100,
      ST_CMP   = 6'b001000,
      ST_UNITS = 6'b010000,
      ST_OUT   = 6'b100000
   } lcr_state_type;

   lcr_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free;

   always_comb begin
      slot_free    = !rsp_valid_ff || !rsp_stall;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd_o        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_o.tick_en = 1'b1;
               if (sts_i.finish) begin
                  cmd_o.div_avg_start = 1'b1;
                  state_in            = ST_AVG;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_AVG: begin
            if (sts_i.div_done) begin
               cmd_o.avg_load = 1'b1;
               state_in       = sts_i.tare ? ST_OUT : ST_MUL;
            end
         end
         ST_MUL: begin
            cmd_o.mul_load = 1'b1;
            state_in       = ST_CMP;
         end
         ST_CMP: begin
            if (sts_i.oor) begin
               cmd_o.oor_set = 1'b1;
               state_in      = ST_OUT;
            end else begin
               cmd_o.div_units_start = 1'b1;
               state_in              = ST_UNITS;
            end
         end
         ST_UNITS: begin
            if (sts_i.div_done) begin
               cmd_o.units_load = 1'b1;
               state_in         = ST_OUT;
            end
         end
         ST_OUT: begin
            if (slot_free) begin
               cmd_o.rsp_load = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hdl/load_cell_adc_reader_core.sv
// Top level of the load cell converter reader with tare.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   req_command, req_data_pin
//   rsp_      out        rsp_valid/rsp_stall   clock pin, busy, done, tare flag,
//                                              out of range, units_q8, raw_average
//   csr_      in         csr_write_en          csr_index, csr_wdata
//
// A request that does not finish an operation is accepted, then handed off to the output
// register once it is free. A finishing measurement runs the bit-serial divider twice:
// sum by sample count, then scaled difference by scale divisor; a finishing tare runs
// it once, and so does a measurement found out of range.
// Reset is synchronous; it loads the register defaults and clears the tare offset.
// The output register lets the next request be accepted while a result is stalled.
module load_cell_adc_reader_core
   import lcr_pkg::*;
#(
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int MAX_SAMPLES   = MAX_SAMPLES_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CMD_W-1:0]      req_command,
   input  logic                  req_data_pin,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_clock_pin,
   output logic                  rsp_busy_res,
   output logic                  rsp_done_res,
   output logic                  rsp_was_tare,
   output logic                  rsp_out_of_range,
   output logic [UNITS_W-1:0]    rsp_units_q8,
   output logic [RAW_W-1:0]      rsp_raw_average,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   lcr_cmd_type cmd;
   lcr_sts_type sts;
   lcr_res_type rsp;

   lcr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts_i     (sts),
      .cmd_o     (cmd)
   );

   lcr_datapath #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .MAX_SAMPLES   (MAX_SAMPLES),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_command  (req_command),
      .req_data_pin (req_data_pin),
      .cmd_i        (cmd),
      .sts_o        (sts),
      .rsp_o        (rsp)
   );

   assign rsp_clock_pin    = rsp.clock_pin;
   assign rsp_busy_res     = rsp.busy_res;
   assign rsp_done_res     = rsp.done_res;
   assign rsp_was_tare     = rsp.was_tare;
   assign rsp_out_of_range = rsp.out_of_range;
   assign rsp_units_q8     = rsp.units_q8;
   assign rsp_raw_average  = rsp.raw_average;

endmodule
